// ===== src/svi_pkg.sv =====
package svi_pkg;

    // Command codes
    localparam logic [2:0] CMD_DECLARE = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_SUB     = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_REFUSED   = 2'd1;
    localparam logic [1:0] STS_VIOLATION = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MEMORY_SIZE   = 1'b0;
    localparam logic CFG_DECLARE_LIMIT = 1'b1;

    localparam logic [15:0] SAT_CEILING = 16'hFFFF;

    // Width used to compare the entry count against the declare limit
    localparam int CNT_CMP_W = 9;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    // Lookup record that walks the row of cells, one cell per cycle
    typedef struct packed {
        logic        valid;
        logic [15:0] key_a;
        logic [15:0] key_b;
        logic [15:0] key_d;
        logic        hit_a;
        logic        hit_b;
        logic        hit_d;
        logic        free_seen;
        logic [15:0] val_a;
        logic [15:0] val_b;
    } probe_t;

    // Store broadcast to the cells marked by the last lookup
    typedef struct packed {
        logic        wr_en;
        logic        alloc;
        logic [15:0] name;
        logic [15:0] value;
    } commit_t;

endpackage

// ===== src/svi_cell.sv =====
module svi_cell
    import svi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  probe_t  probe_i,
    output probe_t  probe_o,
    input  commit_t commit_i
);

    logic        valid_reg;
    logic [15:0] name_reg;
    logic [15:0] value_reg;
    logic        mark_d_reg;
    logic        mark_free_reg;
    probe_t      probe_reg;

    logic   match_a;
    logic   match_b;
    logic   match_d;
    logic   take_free;
    logic   mine;
    probe_t probe_next;

    // Compare this entry against the passing lookup
    always_comb begin
        match_a   = valid_reg && (name_reg == probe_i.key_a) && !probe_i.hit_a;
        match_b   = valid_reg && (name_reg == probe_i.key_b) && !probe_i.hit_b;
        match_d   = valid_reg && (name_reg == probe_i.key_d) && !probe_i.hit_d;
        take_free = !valid_reg && !probe_i.free_seen;

        probe_next           = probe_i;
        probe_next.hit_a     = probe_i.hit_a || match_a;
        probe_next.hit_b     = probe_i.hit_b || match_b;
        probe_next.hit_d     = probe_i.hit_d || match_d;
        probe_next.free_seen = probe_i.free_seen || take_free;
        probe_next.val_a     = match_a ? value_reg : probe_i.val_a;
        probe_next.val_b     = match_b ? value_reg : probe_i.val_b;

        mine = commit_i.wr_en && (commit_i.alloc ? mark_free_reg : mark_d_reg);
    end

    // Advance the lookup to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    assign probe_o = probe_reg;

    // Remember this entry's role for the store that follows the lookup
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_d_reg    <= 1'b0;
            mark_free_reg <= 1'b0;
        end else if (probe_i.valid) begin
            mark_d_reg    <= match_d;
            mark_free_reg <= take_free;
        end
    end

    // Hold the entry, update on store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (mine && commit_i.alloc) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mine) begin
            value_reg <= commit_i.value;
            if (commit_i.alloc) begin
                name_reg <= commit_i.name;
            end
        end
    end

endmodule

// ===== src/svi_chain.sv =====
module svi_chain
    import svi_pkg::*;
#(
    parameter int NUM_VARS = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  probe_t  probe_i,
    output probe_t  probe_o,
    input  commit_t commit_i
);

    probe_t link [NUM_VARS+1];

    assign link[0] = probe_i;

    // Row of entries, lowest index first
    for (genvar i = 0; i < NUM_VARS; i++) begin : g_cell
        svi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .probe_i  (link[i]),
            .probe_o  (link[i+1]),
            .commit_i (commit_i)
        );
    end

    assign probe_o = link[NUM_VARS];

endmodule

// ===== src/saturating_variable_instruction_unit_top.sv =====
// The lookup walks the row of NUM_VARS cells one cell per cycle, resolving
// all three names at once; no new item is accepted until the result of the
// last one has been loaded into the output stage.
// Reset: synchronous, active low; after reset the word memory is cleared
// one word per cycle, so no item is accepted until the sweep has finished.
// Configuration writes are taken at any time, cfg_ready is always high.
module saturating_variable_instruction_unit_top
    import svi_pkg::*;
#(
    parameter int NUM_VARS  = 32,
    parameter int MEM_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [15:0] s_dest_name,
    input  logic [15:0] s_src_a_name,
    input  logic [15:0] s_src_b_name,
    input  logic [9:0]  s_address,
    input  logic [15:0] s_literal,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_value,
    output logic [1:0]  m_status,
    output logic        m_finished
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(NUM_VARS + 1);

    state_t state_reg, state_next;

    logic [AW-1:0] clr_cnt_reg;
    logic [10:0]   memory_size_reg;
    logic [5:0]    declare_limit_reg;
    logic [CW-1:0] count_reg;
    logic          finished_reg;
    logic [2:0]    cmd_reg;
    logic [9:0]    addr_reg;
    logic [15:0]   lit_reg;
    logic [15:0]   rd_data_reg;
    logic [15:0]   res_value_reg;
    logic [1:0]    res_status_reg;
    logic          m_valid_reg;
    logic [15:0]   m_value_reg;
    logic [1:0]    m_status_reg;
    logic          m_finished_reg;
    logic [15:0]   mem [MEM_DEPTH];

    logic          clearing;
    logic          clr_last;
    logic          probe_done;
    logic          out_load;
    logic          in_fire;
    probe_t        probe_in;
    probe_t        probe_out;
    commit_t       commit;
    logic [16:0]   addr_ext;
    logic [AW-1:0] mem_idx;
    logic [16:0]   sum;
    logic [15:0]   arith;
    logic          addr_bad;
    logic          refused;
    logic          can_store;
    logic          store_en;
    logic [15:0]   store_val;
    logic [15:0]   ex_value;
    logic [1:0]    ex_status;
    logic          set_fin;
    logic          mem_we;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign clr_last  = (clr_cnt_reg == AW'(MEM_DEPTH - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_last) state_next = S_IDLE;
            S_IDLE:  if (s_valid) state_next = S_PROBE;
            S_PROBE: if (probe_out.valid) state_next = S_DONE;
            S_DONE:  if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        clearing   = (state_reg == S_CLEAR);
        probe_done = (state_reg == S_PROBE) && probe_out.valid;
        out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_size_reg   <= 11'd1024;
            declare_limit_reg <= 6'd32;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MEMORY_SIZE:   memory_size_reg   <= cfg_data;
                CFG_DECLARE_LIMIT: declare_limit_reg <= cfg_data[5:0];
                default:           memory_size_reg   <= memory_size_reg;
            endcase
        end
    end

    // Capture the instruction beat
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg  <= s_cmd;
            addr_reg <= s_address;
            lit_reg  <= s_literal;
        end
    end

    // Launch the lookup into the row
    always_comb begin
        probe_in       = '0;
        probe_in.valid = in_fire;
        probe_in.key_a = s_src_a_name;
        probe_in.key_b = s_src_b_name;
        probe_in.key_d = s_dest_name;
    end

    svi_chain #(
        .NUM_VARS (NUM_VARS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .probe_i  (probe_in),
        .probe_o  (probe_out),
        .commit_i (commit)
    );

    // Execute once the lookup leaves the row
    always_comb begin
        addr_ext  = 17'(addr_reg);
        mem_idx   = addr_ext[AW-1:0];
        sum       = {1'b0, probe_out.val_a} + {1'b0, probe_out.val_b};
        if (cmd_reg == CMD_ADD) begin
            arith = sum[16] ? SAT_CEILING : sum[15:0];
        end else begin
            arith = (probe_out.val_a > probe_out.val_b) ?
                    (probe_out.val_a - probe_out.val_b) : 16'd0;
        end
        addr_bad  = ((11'(addr_reg) + 11'd1) >= memory_size_reg) ||
                    (addr_ext >= 17'(MEM_DEPTH));
        refused   = (CNT_CMP_W'(count_reg) >= CNT_CMP_W'(declare_limit_reg));
        can_store = probe_out.hit_d || probe_out.free_seen;

        store_en  = 1'b0;
        store_val = 16'd0;
        ex_value  = 16'd0;
        ex_status = STS_OK;
        set_fin   = 1'b0;
        mem_we    = 1'b0;

        unique case (cmd_reg)
            CMD_DECLARE: begin
                if (refused) begin
                    ex_status = STS_REFUSED;
                end else if (can_store) begin
                    store_en  = 1'b1;
                    store_val = lit_reg;
                    ex_value  = lit_reg;
                end else begin
                    ex_status = STS_FULL;
                end
            end
            CMD_ADD, CMD_SUB: begin
                if (can_store) begin
                    store_en  = 1'b1;
                    store_val = arith;
                    ex_value  = arith;
                end else begin
                    ex_status = STS_FULL;
                end
            end
            CMD_WRITE: begin
                if (addr_bad) begin
                    set_fin   = 1'b1;
                    ex_status = STS_VIOLATION;
                end else begin
                    mem_we   = 1'b1;
                    ex_value = probe_out.val_a;
                end
            end
            CMD_READ: begin
                if (addr_bad) begin
                    set_fin   = 1'b1;
                    ex_status = STS_VIOLATION;
                end else if (refused) begin
                    ex_status = STS_REFUSED;
                end else if (can_store) begin
                    store_en  = 1'b1;
                    store_val = rd_data_reg;
                    ex_value  = rd_data_reg;
                end else begin
                    ex_status = STS_FULL;
                end
            end
            default: begin
                ex_status = STS_OK;
            end
        endcase

        commit.wr_en = probe_done && store_en;
        commit.alloc = !probe_out.hit_d;
        commit.name  = probe_out.key_d;
        commit.value = store_val;
    end

    // Entry count and sticky violation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end else if (probe_done) begin
            if (commit.wr_en && commit.alloc) begin
                count_reg <= count_reg + 1'b1;
            end
            if (set_fin) begin
                finished_reg <= 1'b1;
            end
        end
    end

    // Word memory: clear sweep, store, registered read
    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[clr_cnt_reg] <= 16'd0;
        end else if (probe_done && mem_we) begin
            mem[mem_idx] <= probe_out.val_a;
        end
        rd_data_reg <= mem[mem_idx];
    end

    // Hold the result until the output stage frees up
    always_ff @(posedge aclk) begin
        if (probe_done) begin
            res_value_reg  <= ex_value;
            res_status_reg <= ex_status;
        end
    end

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg    <= res_value_reg;
            m_status_reg   <= res_status_reg;
            m_finished_reg <= finished_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_status   = m_status_reg;
    assign m_finished = m_finished_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_CMP_W'(count_reg) <= CNT_CMP_W'(NUM_VARS))
        else $error("entry count above table size");

    a_probe_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        probe_out.valid |-> (state_reg == S_PROBE))
        else $error("lookup left the row outside the probe state");

    a_finished_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared");

    a_alloc_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit.wr_en && commit.alloc) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("allocation did not raise the entry count");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("second item accepted during a lookup");
`endif

endmodule
